[rtl/core/srw_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
// Used by every module and interface in rtl/core; no dependencies.
package srw_pkg;

  localparam int SEQ_W    = 16;
  localparam int MOD_W    = 17;
  localparam int HANDLE_W = 16;
  localparam int DISP_W   = 2;

  localparam int WINDOW_SLOTS_DEF = 16;
  localparam int HANDLE_BITS_DEF  = 16;

  localparam logic [MOD_W-1:0] MOD_MIN = 17'd32;
  localparam logic [MOD_W-1:0] MOD_MAX = 17'd65536;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [DISP_W-1:0] DISP_IN_ORDER = 2'd0;
  localparam logic [DISP_W-1:0] DISP_BUFFERED = 2'd1;
  localparam logic [DISP_W-1:0] DISP_IGNORED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DIST,
    ST_DECIDE,
    ST_EMIT_CUR,
    ST_DRAIN_CHK,
    ST_DRAIN_OUT,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic take;
    logic step;
    logic dist_ld;
    logic decide;
    logic buf_wr;
    logic emit_cur;
    logic emit_slot;
    logic emit_ack;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic d_zero;
    logic d_in_win;
    logic out_free;
    logic slot_hit;
  } status_t;

endpackage

[rtl/core/srw_in_if.sv]
// Segment input channel: valid/ready plus sequence number and buffer handle.
// Depends on srw_pkg.
interface srw_in_if;
  logic                          valid;
  logic                          ready;
  logic [srw_pkg::SEQ_W-1:0]     seq_num;
  logic [srw_pkg::HANDLE_W-1:0]  buf_handle;

  modport source (output valid, output seq_num, output buf_handle, input ready);
  modport sink   (input valid, input seq_num, input buf_handle, output ready);
endinterface

[rtl/core/srw_out_if.sv]
// Result channel: deliveries and cumulative acks with valid/ready.
// Depends on srw_pkg.
interface srw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [srw_pkg::HANDLE_W-1:0]  out_handle;
  logic [srw_pkg::SEQ_W-1:0]     ack_num;
  logic [srw_pkg::DISP_W-1:0]    disposition;
  logic                          last_of_run;

  modport source (output valid, output kind, output out_handle, output ack_num,
                  output disposition, output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_handle, input ack_num,
                  input disposition, input last_of_run, output ready);
endinterface

[rtl/core/srw_cfg_if.sv]
// Configuration write channel carrying the sequence modulus.
// Depends on srw_pkg.
interface srw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [srw_pkg::MOD_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/srw_rem.sv]
// Restoring remainder by the modulus: one dividend bit per cycle with step.
// Depends on srw_pkg.
module srw_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       step,
  input  logic [srw_pkg::SEQ_W-1:0]  dividend,
  input  logic [srw_pkg::MOD_W-1:0]  divisor,
  output logic [srw_pkg::SEQ_W-1:0]  remainder,
  output logic                       last
);

  localparam int CNT_W = $clog2(srw_pkg::SEQ_W);

  logic [CNT_W-1:0]          cnt_r;
  logic [srw_pkg::SEQ_W-1:0] num_r;
  logic [srw_pkg::SEQ_W-1:0] rem_r;
  logic [srw_pkg::MOD_W-1:0] shifted;
  logic [srw_pkg::MOD_W-1:0] rem_nxt;

  // rem_r stays below divisor, so it fits SEQ_W bits before the shift
  assign shifted = {rem_r, num_r[srw_pkg::SEQ_W-1]};
  assign rem_nxt = (shifted >= divisor) ? shifted - divisor : shifted;

  assign remainder = rem_r;
  assign last      = (cnt_r == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      num_r <= {num_r[srw_pkg::SEQ_W-2:0], 1'b0};
      rem_r <= rem_nxt[srw_pkg::SEQ_W-1:0];
    end
  end

endmodule

[rtl/core/srw_dp.sv]
// Datapath: modulus register, remainder units, distance, slot ring and
// output register. Depends on srw_pkg and srw_rem.
module srw_dp #(
  parameter int WINDOW_SLOTS = srw_pkg::WINDOW_SLOTS_DEF,
  parameter int HANDLE_BITS  = srw_pkg::HANDLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srw_pkg::cmd_t                 cmd,
  output srw_pkg::status_t              status,
  input  logic                          in_valid,
  input  logic [srw_pkg::SEQ_W-1:0]     in_seq_num,
  input  logic [srw_pkg::HANDLE_W-1:0]  in_buf_handle,
  input  logic                          cfg_valid,
  input  logic [srw_pkg::MOD_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [srw_pkg::HANDLE_W-1:0]  out_handle,
  output logic [srw_pkg::SEQ_W-1:0]     out_ack_num,
  output logic [srw_pkg::DISP_W-1:0]    out_disposition,
  output logic                          out_last_of_run
);

  localparam int HW      = (HANDLE_BITS < srw_pkg::HANDLE_W) ? HANDLE_BITS
                                                              : srw_pkg::HANDLE_W;
  localparam int SLOT_AW = $clog2(WINDOW_SLOTS);
  localparam int RING    = 1 << SLOT_AW;
  localparam logic [srw_pkg::MOD_W-1:0] WIN_LIM = srw_pkg::MOD_W'(WINDOW_SLOTS);

  logic                          accept;
  logic [srw_pkg::MOD_W-1:0]     mod_r;
  logic [srw_pkg::SEQ_W-1:0]     expected_r;
  logic [srw_pkg::SEQ_W-1:0]     exp_inc;
  logic [HW-1:0]                 hnd_r;
  logic [srw_pkg::MOD_W-1:0]     d_r;
  logic [srw_pkg::MOD_W-1:0]     d_nxt;
  logic [srw_pkg::DISP_W-1:0]    disp_r;
  logic [SLOT_AW-1:0]            base_r;
  logic [SLOT_AW-1:0]            wr_addr;
  logic [RING-1:0]               slot_valid_r;
  logic [HW-1:0]                 slot_mem [RING];
  logic [HW-1:0]                 rd_data_r;
  logic [srw_pkg::SEQ_W-1:0]     seq_rem;
  logic [srw_pkg::SEQ_W-1:0]     exp_rem;
  logic                          seq_last;
  logic                          exp_last;
  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [srw_pkg::HANDLE_W-1:0]  out_handle_r;
  logic [srw_pkg::SEQ_W-1:0]     out_ack_r;
  logic [srw_pkg::DISP_W-1:0]    out_disp_r;
  logic                          out_last_r;

  assign accept = cmd.take && in_valid;

  srw_rem u_seq_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .step      (cmd.step),
    .dividend  (in_seq_num),
    .divisor   (mod_r),
    .remainder (seq_rem),
    .last      (seq_last)
  );

  srw_rem u_exp_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .step      (cmd.step),
    .dividend  (expected_r),
    .divisor   (mod_r),
    .remainder (exp_rem),
    .last      (exp_last)
  );

  // modulus register, saturated on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= srw_pkg::MOD_MAX;
    end else if (cfg_valid) begin
      if (cfg_data < srw_pkg::MOD_MIN) begin
        mod_r <= srw_pkg::MOD_MIN;
      end else if (cfg_data > srw_pkg::MOD_MAX) begin
        mod_r <= srw_pkg::MOD_MAX;
      end else begin
        mod_r <= cfg_data;
      end
    end
  end

  assign d_nxt = (seq_rem < exp_rem)
               ? (mod_r - {1'b0, exp_rem}) + {1'b0, seq_rem}
               : {1'b0, seq_rem} - {1'b0, exp_rem};

  assign exp_inc = (({1'b0, expected_r} + srw_pkg::MOD_W'(1)) == mod_r)
                 ? '0 : expected_r + srw_pkg::SEQ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
    end else if (cmd.dist_ld) begin
      expected_r <= exp_rem;
    end else if (cmd.emit_cur || cmd.emit_slot) begin
      expected_r <= exp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hnd_r <= in_buf_handle[HW-1:0];
    end
    if (cmd.dist_ld) begin
      d_r <= d_nxt;
    end
    if (cmd.decide) begin
      if (d_r == '0) begin
        disp_r <= srw_pkg::DISP_IN_ORDER;
      end else if (d_r < WIN_LIM) begin
        disp_r <= srw_pkg::DISP_BUFFERED;
      end else begin
        disp_r <= srw_pkg::DISP_IGNORED;
      end
    end
  end

  // slot ring: base_r is the ring position of the slot one past expected
  assign wr_addr = base_r + d_r[SLOT_AW-1:0] - SLOT_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      slot_valid_r <= '0;
    end else begin
      if (cmd.buf_wr) begin
        slot_valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.emit_slot) begin
        slot_valid_r[base_r] <= 1'b0;
        base_r               <= base_r + SLOT_AW'(1);
      end else if (cmd.emit_ack && disp_r == srw_pkg::DISP_IN_ORDER) begin
        base_r <= base_r + SLOT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      slot_mem[wr_addr] <= hnd_r;
    end
    rd_data_r <= slot_mem[base_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_cur || cmd.emit_slot || cmd.emit_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cur || cmd.emit_slot) begin
      out_kind_r   <= srw_pkg::KIND_DELIVER;
      out_handle_r <= cmd.emit_cur ? srw_pkg::HANDLE_W'(hnd_r)
                                   : srw_pkg::HANDLE_W'(rd_data_r);
      out_ack_r    <= '0;
      out_disp_r   <= srw_pkg::DISP_IN_ORDER;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_ack) begin
      out_kind_r   <= srw_pkg::KIND_ACK;
      out_handle_r <= '0;
      out_ack_r    <= expected_r;
      out_disp_r   <= disp_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_handle      = out_handle_r;
  assign out_ack_num     = out_ack_r;
  assign out_disposition = out_disp_r;
  assign out_last_of_run = out_last_r;

  assign status.mod_done = seq_last && exp_last;
  assign status.d_zero   = (d_r == '0);
  assign status.d_in_win = (d_r < WIN_LIM);
  assign status.out_free = !out_valid_r || out_ready;
  assign status.slot_hit = slot_valid_r[base_r];

endmodule

[rtl/core/srw_ctrl.sv]
// Controller state machine: sequences reduce, classify, drain and ack.
// Depends on srw_pkg.
module srw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  srw_pkg::status_t  status,
  output srw_pkg::cmd_t     cmd
);

  srw_pkg::state_t state_r;
  srw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = srw_pkg::ST_REDUCE;
      end
      srw_pkg::ST_REDUCE: begin
        if (status.mod_done) state_nxt = srw_pkg::ST_DIST;
      end
      srw_pkg::ST_DIST: begin
        state_nxt = srw_pkg::ST_DECIDE;
      end
      srw_pkg::ST_DECIDE: begin
        state_nxt = status.d_zero ? srw_pkg::ST_EMIT_CUR : srw_pkg::ST_ACK;
      end
      srw_pkg::ST_EMIT_CUR: begin
        if (status.out_free) state_nxt = srw_pkg::ST_DRAIN_CHK;
      end
      srw_pkg::ST_DRAIN_CHK: begin
        state_nxt = status.slot_hit ? srw_pkg::ST_DRAIN_OUT : srw_pkg::ST_ACK;
      end
      srw_pkg::ST_DRAIN_OUT: begin
        if (status.out_free) state_nxt = srw_pkg::ST_DRAIN_CHK;
      end
      srw_pkg::ST_ACK: begin
        if (status.out_free) state_nxt = srw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = srw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      srw_pkg::ST_IDLE:      cmd.take      = 1'b1;
      srw_pkg::ST_REDUCE:    cmd.step      = 1'b1;
      srw_pkg::ST_DIST:      cmd.dist_ld   = 1'b1;
      srw_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.buf_wr = !status.d_zero && status.d_in_win;
      end
      srw_pkg::ST_EMIT_CUR:  cmd.emit_cur  = status.out_free;
      srw_pkg::ST_DRAIN_OUT: cmd.emit_slot = status.out_free;
      srw_pkg::ST_ACK:       cmd.emit_ack  = status.out_free;
      default:               cmd           = '0;
    endcase
  end

endmodule

[rtl/core/selective_repeat_receive_window_unit.sv]
// Selective-repeat receive window, top level. One segment is processed at a
// time: after the accept beat, both the segment number and the stored expected
// number are reduced modulo the configured modulus by two bit-serial remainder
// units, then the distance is formed (ST_DIST) and classified (ST_DECIDE).
// A buffered or ignored segment then yields its ack; an in-order segment is
// delivered and then drains the buffered slots that follow it in order, where
// each drained handle needs a slot check plus a registered read of the slot
// memory. Output stalls lengthen the processing; the input is ready again from
// the edge that loads the ack beat into the output register.
// Depends on srw_pkg, srw_in_if, srw_out_if, srw_cfg_if, srw_ctrl, srw_dp.
module selective_repeat_receive_window_unit #(
  parameter int WINDOW_SLOTS = srw_pkg::WINDOW_SLOTS_DEF,
  parameter int HANDLE_BITS  = srw_pkg::HANDLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  srw_in_if.sink     in_ch,
  srw_out_if.source  out_ch,
  srw_cfg_if.sink    cfg_ch
);

  srw_pkg::cmd_t    cmd;
  srw_pkg::status_t status;

  assign in_ch.ready  = cmd.take;
  assign cfg_ch.ready = 1'b1;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  srw_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_valid        (in_ch.valid),
    .in_seq_num      (in_ch.seq_num),
    .in_buf_handle   (in_ch.buf_handle),
    .cfg_valid       (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_handle      (out_ch.out_handle),
    .out_ack_num     (out_ch.ack_num),
    .out_disposition (out_ch.disposition),
    .out_last_of_run (out_ch.last_of_run)
  );

endmodule

[rtl/core/srw_checker.sv]
// Port-level checks for the receive window unit, bound to the top level.
// Depends on srw_pkg and selective_repeat_receive_window_unit.
module srw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [srw_pkg::HANDLE_W-1:0]  out_handle,
  input logic [srw_pkg::SEQ_W-1:0]     out_ack_num,
  input logic [srw_pkg::DISP_W-1:0]    out_disposition,
  input logic                          out_last_of_run
);

  // ack closes each run
  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_run == (out_kind == srw_pkg::KIND_ACK)))
    else $error("last_of_run does not match ack beat");

  a_deliver_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == srw_pkg::KIND_DELIVER) |->
      (out_disposition == srw_pkg::DISP_IN_ORDER && out_ack_num == '0))
    else $error("delivery beat carries ack fields");

  a_ack_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == srw_pkg::KIND_ACK) |->
      (out_handle == '0 && (out_disposition == srw_pkg::DISP_IN_ORDER ||
                            out_disposition == srw_pkg::DISP_BUFFERED ||
                            out_disposition == srw_pkg::DISP_IGNORED)))
    else $error("ack beat malformed");

  // one segment in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while segment in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_handle) &&
       $stable(out_ack_num) && $stable(out_disposition)))
    else $error("stalled result beat changed");

endmodule

bind selective_repeat_receive_window_unit srw_checker u_srw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_handle      (out_ch.out_handle),
  .out_ack_num     (out_ch.ack_num),
  .out_disposition (out_ch.disposition),
  .out_last_of_run (out_ch.last_of_run)
);

[tb/tb_selective_repeat_receive_window_unit.sv]
`timescale 1ns / 100ps
// Self-checking bench for selective_repeat_receive_window_unit: directed rows, then random
// segments under bursty input and a stalling result sink, checked against a window model.
// Depends on srw_pkg, srw_in_if, srw_out_if, srw_cfg_if and the unit itself.
module tb_selective_repeat_receive_window_unit;

  localparam int NSLOT = srw_pkg::WINDOW_SLOTS_DEF - 1;
  localparam logic [srw_pkg::HANDLE_W-1:0] HND_MASK =
    srw_pkg::HANDLE_W'((64'd1 << srw_pkg::HANDLE_BITS_DEF) - 1);
  localparam int N_DIR = 26;
  localparam int N_PHASE = 6;
  localparam int PHASE_SEGS = 58;

  typedef struct packed {
    logic                         kind;
    logic [srw_pkg::HANDLE_W-1:0] hnd;
    logic [srw_pkg::SEQ_W-1:0]    ack;
    logic [srw_pkg::DISP_W-1:0]   disp;
    logic                         last;
  } win_beat_t;

  typedef enum logic [1:0] {ROW_SEG, ROW_PINNED, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pat_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [srw_pkg::MOD_W-1:0]    mod_wr;
    logic [srw_pkg::SEQ_W-1:0]    seq;
    logic [srw_pkg::HANDLE_W-1:0] hnd;
    logic [srw_pkg::SEQ_W-1:0]    ack;
    logic [srw_pkg::DISP_W-1:0]   disp;
  } dir_row_t;

  // pinned rows carry the ack number and disposition of their final beat
  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_PINNED, 17'd0, 16'd65535, 16'hFFFF, 16'd0,  srw_pkg::DISP_IGNORED},
    '{ROW_PINNED, 17'd0, 16'd16,    16'h0001, 16'd0,  srw_pkg::DISP_IGNORED},
    '{ROW_PINNED, 17'd0, 16'd15,    16'h8000, 16'd0,  srw_pkg::DISP_BUFFERED},
    '{ROW_SEG,    17'd0, 16'd14,    16'h7001, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd13,    16'h7002, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd12,    16'h7003, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd11,    16'h7004, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd10,    16'h7005, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd9,     16'h7006, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd8,     16'h7007, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd7,     16'h7008, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd6,     16'h7009, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd5,     16'h700A, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd4,     16'h700B, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd3,     16'h700C, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd2,     16'h700D, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd1,     16'h0000, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_SEG,    17'd0, 16'd8,     16'hAAAA, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_PINNED, 17'd0, 16'd0,     16'h5555, 16'd16, srw_pkg::DISP_IN_ORDER},
    '{ROW_PINNED, 17'd0, 16'd5,     16'hFFFF, 16'd16, srw_pkg::DISP_IGNORED},
    '{ROW_CFG,    17'd0, 16'd0,     16'h0000, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_PINNED, 17'd0, 16'd65535, 16'h1111, 16'd16, srw_pkg::DISP_BUFFERED},
    '{ROW_PINNED, 17'd0, 16'd48,    16'h2222, 16'd17, srw_pkg::DISP_IN_ORDER},
    '{ROW_PINNED, 17'd0, 16'd65520, 16'h3333, 16'd17, srw_pkg::DISP_IGNORED},
    '{ROW_CFG,    17'h1FFFF, 16'd0, 16'h0000, 16'd0,  srw_pkg::DISP_IN_ORDER},
    '{ROW_PINNED, 17'd0, 16'd17,    16'h0F0F, 16'd18, srw_pkg::DISP_IN_ORDER}
  };

  logic clk = 1'b0;
  logic rst_n;

  srw_in_if  in_ch();
  srw_out_if out_ch();
  srw_cfg_if cfg_ch();

  selective_repeat_receive_window_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // window model state
  logic [srw_pkg::MOD_W-1:0]    win_mod = srw_pkg::MOD_MAX;
  int unsigned                  win_next = 0;
  bit                           slot_full [NSLOT];
  logic [srw_pkg::HANDLE_W-1:0] slot_buf [NSLOT];
  win_beat_t                    owed_beats [$];

  int          mismatch_cnt = 0;
  bit          pin_on = 1'b0;
  logic [srw_pkg::SEQ_W-1:0]  pin_ack = '0;
  logic [srw_pkg::DISP_W-1:0] pin_disp = '0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          rx_left = 0;
  rx_pat_t     rx_pat = RX_OPEN;
  int unsigned rx_tick = 0;
  win_beat_t   got_beat, want_beat;

  function automatic win_beat_t make_beat(logic kind, logic [srw_pkg::HANDLE_W-1:0] hnd,
                                          logic [srw_pkg::SEQ_W-1:0] ack,
                                          logic [srw_pkg::DISP_W-1:0] disp,
                                          logic last);
    win_beat_t b;
    b.kind = kind;
    b.hnd  = hnd;
    b.ack  = ack;
    b.disp = disp;
    b.last = last;
    return b;
  endfunction

  function automatic string beat_str(win_beat_t b);
    return $sformatf("kind=%0d handle=%h ack=%0d disp=%0d last=%0d",
                     b.kind, b.hnd, b.ack, b.disp, b.last);
  endfunction

  task automatic window_advance(input logic [srw_pkg::SEQ_W-1:0] seq_in,
                                input logic [srw_pkg::HANDLE_W-1:0] hnd_in);
    int unsigned m, s, e, d, run, adv, i;
    logic [srw_pkg::HANDLE_W-1:0] h;
    logic [srw_pkg::DISP_W-1:0] disp;
    m = win_mod;
    s = seq_in % m;
    h = hnd_in & HND_MASK;
    e = win_next % m;
    d = (s + m - e) % m;
    if (d == 0) begin
      disp = srw_pkg::DISP_IN_ORDER;
      owed_beats.push_back(make_beat(srw_pkg::KIND_DELIVER, h, '0,
                                     srw_pkg::DISP_IN_ORDER, 1'b0));
      run = 0;
      while (run < NSLOT && slot_full[run]) begin
        owed_beats.push_back(make_beat(srw_pkg::KIND_DELIVER, slot_buf[run], '0,
                                       srw_pkg::DISP_IN_ORDER, 1'b0));
        run++;
      end
      adv = run + 1;
      for (i = 0; i < NSLOT; i++) begin
        if (i + adv < NSLOT) begin
          slot_full[i] = slot_full[i + adv];
          slot_buf[i]  = slot_buf[i + adv];
        end else begin
          slot_full[i] = 1'b0;
        end
      end
      e = (e + adv) % m;
    end else if (d < srw_pkg::WINDOW_SLOTS_DEF) begin
      disp = srw_pkg::DISP_BUFFERED;
      slot_full[d - 1] = 1'b1;
      slot_buf[d - 1]  = h;
    end else begin
      disp = srw_pkg::DISP_IGNORED;
    end
    win_next = e;
    owed_beats.push_back(make_beat(srw_pkg::KIND_ACK, '0, srw_pkg::SEQ_W'(e), disp, 1'b1));
  endtask

  // mostly in-window numbers, some far ones, some aliased above the modulus
  function automatic logic [srw_pkg::SEQ_W-1:0] pick_seq();
    int unsigned m, e, d, s, k;
    int r;
    m = win_mod;
    e = win_next % m;
    r = $urandom_range(0, 99);
    if (r >= 88) return srw_pkg::SEQ_W'($urandom);
    if (r < 30) d = 0;
    else if (r < 75) d = $urandom_range(1, srw_pkg::WINDOW_SLOTS_DEF - 1);
    else d = $urandom_range(srw_pkg::WINDOW_SLOTS_DEF, m - 1);
    s = (e + d) % m;
    k = (65535 - s) / m;
    if (k > 0 && $urandom_range(0, 3) == 0) s += m * $urandom_range(1, k);
    return srw_pkg::SEQ_W'(s);
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.data < srw_pkg::MOD_MIN) win_mod = srw_pkg::MOD_MIN;
      else if (cfg_ch.data > srw_pkg::MOD_MAX) win_mod = srw_pkg::MOD_MAX;
      else win_mod = cfg_ch.data;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      window_advance(in_ch.seq_num, in_ch.buf_handle);
      if (pin_on) begin
        owed_beats[owed_beats.size() - 1].ack  = pin_ack;
        owed_beats[owed_beats.size() - 1].disp = pin_disp;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat = make_beat(out_ch.kind, out_ch.out_handle, out_ch.ack_num,
                           out_ch.disposition, out_ch.last_of_run);
      if (owed_beats.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat, expected none, actual %s", $time, beat_str(got_beat));
      end else begin
        want_beat = owed_beats.pop_front();
        if (got_beat.kind !== want_beat.kind || got_beat.hnd !== want_beat.hnd ||
            got_beat.ack !== want_beat.ack || got_beat.disp !== want_beat.disp ||
            got_beat.last !== want_beat.last) begin
          mismatch_cnt++;
          $display("%0t: mismatch, expected %s, actual %s", $time,
                   beat_str(want_beat), beat_str(got_beat));
        end
      end
    end
  end

  // result sink: changing stall patterns, plus one long hold on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left = $urandom_range(16, 120);
        rx_pat = rx_pat_t'($urandom_range(0, 3));
      end
      rx_left--;
      case (rx_pat)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= rx_tick[1];
      endcase
    end
  end

  task automatic send_seg(input logic [srw_pkg::SEQ_W-1:0] seq,
                          input logic [srw_pkg::HANDLE_W-1:0] hnd);
    in_ch.valid      <= 1'b1;
    in_ch.seq_num    <= seq;
    in_ch.buf_handle <= hnd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_modulus(input logic [srw_pkg::MOD_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (owed_beats.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int i, ph, sent, n, j, gap, gap_max;
    int unsigned e, m;
    bit paused;
    logic [srw_pkg::MOD_W-1:0] phase_mod [N_PHASE];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.seq_num    = '0;
    in_ch.buf_handle = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    for (i = 0; i < NSLOT; i++) slot_full[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_modulus(dir_rows[i].mod_wr);
      end else begin
        pin_on   = (dir_rows[i].kind == ROW_PINNED);
        pin_ack  = dir_rows[i].ack;
        pin_disp = dir_rows[i].disp;
        send_seg(dir_rows[i].seq, dir_rows[i].hnd);
      end
    end
    pin_on = 1'b0;

    phase_mod[0] = srw_pkg::MOD_MIN;
    phase_mod[1] = srw_pkg::MOD_MAX;
    phase_mod[2] = 17'd1000;
    phase_mod[3] = 17'd5;
    phase_mod[4] = srw_pkg::MOD_W'($urandom_range(33, 65535));
    phase_mod[5] = srw_pkg::MOD_W'($urandom_range(33, 300));

    for (ph = 0; ph < N_PHASE; ph++) begin
      write_modulus(phase_mod[ph]);
      if (ph == 1) hold_req = 1'b1;
      gap_max = (ph == 0) ? 0 : 8;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_SEGS) begin
        if (ph == 3 && !paused && sent >= PHASE_SEGS / 2) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          @(negedge clk);
          while (owed_beats.size() != 0) @(negedge clk);
        end
        if ($urandom_range(0, 7) == 0) begin
          // out-of-order fill followed by the missing head: long drains
          m = win_mod;
          e = win_next % m;
          n = $urandom_range(2, NSLOT);
          for (j = n; j >= 1; j--) begin
            send_seg(srw_pkg::SEQ_W'((e + j) % m), srw_pkg::HANDLE_W'($urandom));
          end
          send_seg(srw_pkg::SEQ_W'(e), srw_pkg::HANDLE_W'($urandom));
          sent += n + 1;
        end else begin
          n = $urandom_range(1, 10);
          repeat (n) send_seg(pick_seq(), srw_pkg::HANDLE_W'($urandom));
          sent += n;
        end
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed_beats.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && owed_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (owed_beats.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, owed_beats.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("%0t: timeout, %0d beats still expected", $time, owed_beats.size());
    $display("Verification failed");
    $finish;
  end

endmodule
